>>> rtl/rbd_pkg.sv
package rbd_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int ITEM_WIDTH_DEF = 32;

   localparam int ACTION_W = 3;
   localparam int ITEM_W   = 32;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_CLEAR      = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   typedef struct packed {
      logic load;   // capture the request action and item
      logic exec;   // perform the action on pointers and store
   } cmd_type;

endpackage

>>> rtl/rbd_ctrl.sv
module rbd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_valid,
   output rbd_pkg::cmd_type cmd
);
   import rbd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            // next item may be taken while the result is shown
            state_in = start ? S_EXEC : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      busy      = (state_ff == S_EXEC);
      rsp_valid = (state_ff == S_RESP);
      cmd.load  = start && (state_ff != S_EXEC);
      cmd.exec  = (state_ff == S_EXEC);
   end

endmodule

>>> rtl/rbd_dp.sv
module rbd_dp #(
   parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
   parameter int ITEM_WIDTH = rbd_pkg::ITEM_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rbd_pkg::cmd_type             cmd,
   input  logic [rbd_pkg::ACTION_W-1:0] req_action,
   input  logic [rbd_pkg::ITEM_W-1:0]   req_item,
   output logic [rbd_pkg::ITEM_W-1:0]   rsp_item_out,
   output logic [rbd_pkg::STATUS_W-1:0] rsp_status,
   output logic [rbd_pkg::FILL_W-1:0]   rsp_fill_level
);
   import rbd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [ITEM_WIDTH-1:0] mem [DEPTH];

   action_type            action_ff;
   logic [ITEM_WIDTH-1:0] item_ff;
   logic [PTR_W-1:0]      front_ff, front_in;
   logic [PTR_W-1:0]      back_ff, back_in;
   logic [CNT_W-1:0]      occ_ff, occ_in;
   status_type            status_ff, status_in;
   logic                  pop_ok_ff, pop_ok_in;
   logic [ITEM_WIDTH-1:0] rd_data_ff;

   logic             wr_en, rd_en;
   logic [PTR_W-1:0] addr;
   logic             full, empty;
   logic [PTR_W-1:0] front_inc, front_dec, back_inc, back_dec;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= action_type'(req_action);
         item_ff   <= ITEM_WIDTH'(req_item);
      end
   end

   always_comb begin
      full      = (occ_ff == CNT_FULL);
      empty     = (occ_ff == '0);
      front_inc = (front_ff == PTR_LAST) ? '0 : front_ff + 1'b1;
      front_dec = (front_ff == '0) ? PTR_LAST : front_ff - 1'b1;
      back_inc  = (back_ff == PTR_LAST) ? '0 : back_ff + 1'b1;
      back_dec  = (back_ff == '0) ? PTR_LAST : back_ff - 1'b1;
   end

   always_comb begin
      front_in  = front_ff;
      back_in   = back_ff;
      occ_in    = occ_ff;
      status_in = STAT_OK;
      pop_ok_in = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      addr      = front_ff;
      unique case (action_ff)
         ACT_PUSH_FRONT: begin
            if (full) begin
               status_in = STAT_FULL;
            end else begin
               wr_en    = 1'b1;
               addr     = front_dec;
               front_in = front_dec;
               occ_in   = occ_ff + 1'b1;
            end
         end
         ACT_PUSH_BACK: begin
            if (full) begin
               status_in = STAT_FULL;
            end else begin
               wr_en   = 1'b1;
               addr    = back_ff;
               back_in = back_inc;
               occ_in  = occ_ff + 1'b1;
            end
         end
         ACT_POP_FRONT: begin
            if (empty) begin
               status_in = STAT_EMPTY;
            end else begin
               rd_en     = 1'b1;
               pop_ok_in = 1'b1;
               addr      = front_ff;
               front_in  = front_inc;
               occ_in    = occ_ff - 1'b1;
            end
         end
         ACT_POP_BACK: begin
            if (empty) begin
               status_in = STAT_EMPTY;
            end else begin
               rd_en     = 1'b1;
               pop_ok_in = 1'b1;
               addr      = back_dec;
               back_in   = back_dec;
               occ_in    = occ_ff - 1'b1;
            end
         end
         ACT_CLEAR: begin
            front_in = '0;
            back_in  = '0;
            occ_in   = '0;
         end
         default: begin
            // undefined action: no-op
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         occ_ff   <= '0;
      end else if (cmd.exec) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         pop_ok_ff <= pop_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem[addr] <= item_ff;
      end
      if (cmd.exec && rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rsp_item_out   = pop_ok_ff ? ITEM_W'(rd_data_ff) : '0;
   assign rsp_status     = status_ff;
   assign rsp_fill_level = FILL_W'(occ_ff);

endmodule

>>> rtl/ring_buffer_deque.sv
// An item accepted at one edge is executed in the next cycle and its result
// strobes on rsp_valid in the cycle after that.
// A new start is ignored during the execute cycle in which busy is high; it is
// taken while the previous result is on the ports.
// Reset (synchronous): queue empty, positions zero; store contents stay undefined.
// The receiver cannot stall: each result is valid for exactly one cycle.
module ring_buffer_deque #(
   parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
   parameter int ITEM_WIDTH = rbd_pkg::ITEM_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [rbd_pkg::ACTION_W-1:0] req_action,
   input  logic [rbd_pkg::ITEM_W-1:0]   req_item,
   output logic                         rsp_valid,
   output logic [rbd_pkg::ITEM_W-1:0]   rsp_item_out,
   output logic [rbd_pkg::STATUS_W-1:0] rsp_status,
   output logic [rbd_pkg::FILL_W-1:0]   rsp_fill_level
);
   import rbd_pkg::*;

   cmd_type cmd;

   rbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   rbd_dp #(
      .DEPTH      (DEPTH),
      .ITEM_WIDTH (ITEM_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_action     (req_action),
      .req_item       (req_item),
      .rsp_item_out   (rsp_item_out),
      .rsp_status     (rsp_status),
      .rsp_fill_level (rsp_fill_level)
   );

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not enter execution");

   a_exec_resp: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_valid && !busy))
      else $error("execution not followed by a result");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_EMPTY) |->
         (rsp_item_out == '0 && rsp_fill_level == '0))
      else $error("empty pop reported data or nonzero fill");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_FULL) |->
         (rsp_fill_level == FILL_W'(DEPTH) && rsp_item_out == '0))
      else $error("refused push reported wrong fill or data");

endmodule
